/* design/midi_thru_merge_scheduler_unit_assert.svh */
// assertion macros for the midi thru merge scheduler checker
// expects clk and rst_n in the scope of every use
`ifndef MIDI_THRU_MERGE_SCHEDULER_UNIT_ASSERT_SVH
`define MIDI_THRU_MERGE_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define MTMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mtms_pkg.sv */
// shared constants, codes and sysex helpers for the midi thru merge scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtms_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_SENDS   = 32;
    localparam int HEAD_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SENDS_W     = $clog2(MAX_SENDS + 1);
    localparam int ENTRY_W     = 64;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_THRU  = 2'd1;
    localparam logic [1:0] ACT_QUEUE = 2'd2;

    localparam logic [2:0] ST_FORWARDED = 3'd0;
    localparam logic [2:0] ST_STRAY     = 3'd1;
    localparam logic [2:0] ST_HELD      = 3'd2;
    localparam logic [2:0] ST_QUEUED    = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_SENT      = 3'd5;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] RT_MASK     = 8'hF8;

    function automatic logic has_eox(input logic [31:0] m);
        return (m[7:0] == SYSEX_END) || (m[15:8] == SYSEX_END) ||
               (m[23:16] == SYSEX_END) || (m[31:24] == SYSEX_END);
    endfunction

    function automatic logic is_realtime(input logic [31:0] m);
        return (m[7:0] & RT_MASK) == RT_MASK;
    endfunction

    function automatic logic sysex_track(input logic open, input logic [31:0] m);
        logic o;
        o = open;
        if (m[7:0] == SYSEX_START)
            o = 1'b1;
        else if (!is_realtime(m))
            o = 1'b0;
        if (o && has_eox(m))
            o = 1'b0;
        return o;
    endfunction

endpackage

`default_nettype wire

/* design/mtms_item_if.sv */
// input channel of the midi thru merge scheduler: action, message, send time
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mtms_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] message;
    logic [31:0] send_time;

    modport source (output valid, action, message, send_time, input ready);
    modport sink   (input valid, action, message, send_time, output ready);
endinterface

`default_nettype wire

/* design/mtms_result_if.sv */
// result channel of the midi thru merge scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mtms_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_message;
    logic        to_port;
    logic        to_app;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, out_message, to_port, to_app, status, last, input ready);
    modport sink   (input valid, out_message, to_port, to_app, status, last, output ready);
endinterface

`default_nettype wire

/* design/mtms_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mtms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/midi_thru_merge_scheduler_unit.sv */
// Merges a MIDI thru stream with time-stamped application messages held in a
// queue memory (message and send time per entry). A thru message or a queue
// request gives exactly one result, in the cycle after its transaction. A tick
// advances time and, when enabled with a non-empty queue, reads the queue head
// from the memory; each due entry is held as pending until the check of the
// next entry shows whether it closes the burst, then sent, with at most 32
// entries sent per tick. Such a tick holds the input until the burst is closed,
// and a send waits while the result is stalled; the registered read data of
// the queue memory sets this pace. A tick with an empty queue or while
// disabled gives no result. One item is worked on at a time; the result
// register lets a new item in while the last result is being taken. The queue
// needs no clearing pass.
// depends on mtms_pkg, mtms_item_if, mtms_result_if, mtms_ram
`timescale 1ns / 1ps
`default_nettype none

module midi_thru_merge_scheduler_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mtms_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mtms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    mtms_item_if.sink                               item,
    mtms_result_if.source                           result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    logic        enable_reg, enable_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] last_input_reg, last_input_next;
    logic        thru_open_reg, thru_open_next;
    logic        app_open_reg, app_open_next;
    logic [mtms_pkg::HEAD_W-1:0]  head_reg, head_next;
    logic [mtms_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [mtms_pkg::SENDS_W-1:0] sends_reg, sends_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [31:0] pend_msg_reg, pend_msg_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_msg_reg, out_msg_next;
    logic        out_port_reg, out_port_next;
    logic        out_app_reg, out_app_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic        out_last_reg, out_last_next;

    logic                                ram_we;
    logic                                ram_re;
    logic [mtms_pkg::HEAD_W-1:0]         ram_waddr;
    logic [mtms_pkg::HEAD_W-1:0]         ram_raddr;
    logic [mtms_pkg::ENTRY_W-1:0]        ram_rdata;

    logic                                out_busy;
    logic                                accept;
    logic [mtms_pkg::HEAD_W-1:0]         head_inc;
    logic [mtms_pkg::COUNT_W:0]          tail_sum;
    logic [mtms_pkg::HEAD_W-1:0]         tail;
    logic                                queue_full;

    logic [31:0] entry_msg;
    logic [31:0] entry_time;
    logic [31:0] elapsed;
    logic [31:0] idle_time;
    logic        entry_rt;
    logic        timed_out;
    logic        sendable;

    mtms_ram #(
        .WIDTH (mtms_pkg::ENTRY_W),
        .DEPTH (mtms_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({item.send_time, item.message}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_busy = out_valid_reg && !result.ready;
    assign item.ready = (state_reg == S_IDLE) && !out_busy;
    assign accept = item.valid && item.ready;

    assign head_inc = (head_reg == mtms_pkg::HEAD_W'(mtms_pkg::QUEUE_DEPTH - 1))
                      ? '0 : head_reg + 1'b1;
    assign tail_sum = {1'b0, mtms_pkg::COUNT_W'(head_reg)} + {1'b0, count_reg};
    assign tail = (tail_sum >= (mtms_pkg::COUNT_W + 1)'(mtms_pkg::QUEUE_DEPTH))
                  ? mtms_pkg::HEAD_W'(tail_sum - (mtms_pkg::COUNT_W + 1)'(mtms_pkg::QUEUE_DEPTH))
                  : mtms_pkg::HEAD_W'(tail_sum);
    assign queue_full = (count_reg == mtms_pkg::COUNT_W'(mtms_pkg::QUEUE_DEPTH));

    // head entry checks, valid in S_EVAL
    assign entry_msg  = ram_rdata[31:0];
    assign entry_time = ram_rdata[63:32];
    assign elapsed    = now_reg - entry_time;
    assign idle_time  = now_reg - last_input_reg;
    assign entry_rt   = mtms_pkg::is_realtime(entry_msg);
    assign timed_out  = idle_time > {16'd0, timeout_reg};
    assign sendable   = !elapsed[31] && (entry_rt || !thru_open_reg || timed_out);

    assign ram_waddr = tail;
    assign ram_raddr = (state_reg == S_IDLE) ? head_reg : head_inc;

    always_comb
    begin
        state_next      = state_reg;
        enable_next     = enable_reg;
        timeout_next    = timeout_reg;
        now_next        = now_reg;
        last_input_next = last_input_reg;
        thru_open_next  = thru_open_reg;
        app_open_next   = app_open_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        sends_next      = sends_reg;
        pend_valid_next = pend_valid_reg;
        pend_msg_next   = pend_msg_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_msg_next    = out_msg_reg;
        out_port_next   = out_port_reg;
        out_app_next    = out_app_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                mtms_pkg::CFG_ENABLE:  enable_next  = cfg_wdata[0];
                mtms_pkg::CFG_TIMEOUT: timeout_next = cfg_wdata[15:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        mtms_pkg::ACT_TICK:
                        begin
                            now_next = now_reg + 32'd1;
                            if (enable_reg && (count_reg != '0))
                            begin
                                ram_re     = 1'b1;
                                sends_next = '0;
                                state_next = S_EVAL;
                            end
                        end
                        mtms_pkg::ACT_THRU:
                        begin
                            out_valid_next = 1'b1;
                            out_msg_next   = item.message;
                            out_last_next  = 1'b1;
                            out_port_next  = 1'b0;
                            out_app_next   = 1'b0;
                            if (!enable_reg || app_open_reg)
                                out_status_next = mtms_pkg::ST_HELD;
                            else
                            begin
                                last_input_next = now_reg;
                                if (!item.message[7] && !thru_open_reg)
                                    out_status_next = mtms_pkg::ST_STRAY;
                                else
                                begin
                                    out_status_next = mtms_pkg::ST_FORWARDED;
                                    out_port_next   = 1'b1;
                                    out_app_next    = 1'b1;
                                    thru_open_next  =
                                        mtms_pkg::sysex_track(thru_open_reg, item.message);
                                end
                            end
                        end
                        mtms_pkg::ACT_QUEUE:
                        begin
                            out_valid_next = 1'b1;
                            out_msg_next   = item.message;
                            out_last_next  = 1'b1;
                            out_port_next  = 1'b0;
                            out_app_next   = 1'b0;
                            if (queue_full)
                                out_status_next = mtms_pkg::ST_FULL;
                            else
                            begin
                                ram_we          = 1'b1;
                                count_next      = count_reg + 1'b1;
                                out_status_next = mtms_pkg::ST_QUEUED;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_EVAL:
            begin
                // the previous send waits here until we know whether it closes the burst
                if (!(pend_valid_reg && out_busy))
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_msg_next    = pend_msg_reg;
                        out_port_next   = 1'b1;
                        out_app_next    = 1'b0;
                        out_status_next = mtms_pkg::ST_SENT;
                        out_last_next   = !sendable;
                    end
                    if (sendable)
                    begin
                        pend_valid_next = 1'b1;
                        pend_msg_next   = entry_msg;
                        if (!entry_rt)
                            thru_open_next = 1'b0;
                        app_open_next = mtms_pkg::sysex_track(app_open_reg, entry_msg);
                        head_next     = head_inc;
                        count_next    = count_reg - 1'b1;
                        sends_next    = sends_reg + 1'b1;
                        if ((count_reg == mtms_pkg::COUNT_W'(1)) ||
                            (sends_reg == mtms_pkg::SENDS_W'(mtms_pkg::MAX_SENDS - 1)))
                            state_next = S_FLUSH;
                        else
                            ram_re = 1'b1;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_msg_next    = pend_msg_reg;
                    out_port_next   = 1'b1;
                    out_app_next    = 1'b0;
                    out_status_next = mtms_pkg::ST_SENT;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            enable_reg     <= 1'b0;
            timeout_reg    <= mtms_pkg::TIMEOUT_RESET;
            now_reg        <= '0;
            last_input_reg <= '0;
            thru_open_reg  <= 1'b0;
            app_open_reg   <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            sends_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_msg_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_msg_reg    <= '0;
            out_port_reg   <= 1'b0;
            out_app_reg    <= 1'b0;
            out_status_reg <= mtms_pkg::ST_FORWARDED;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            enable_reg     <= enable_next;
            timeout_reg    <= timeout_next;
            now_reg        <= now_next;
            last_input_reg <= last_input_next;
            thru_open_reg  <= thru_open_next;
            app_open_reg   <= app_open_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            sends_reg      <= sends_next;
            pend_valid_reg <= pend_valid_next;
            pend_msg_reg   <= pend_msg_next;
            out_valid_reg  <= out_valid_next;
            out_msg_reg    <= out_msg_next;
            out_port_reg   <= out_port_next;
            out_app_reg    <= out_app_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_message = out_msg_reg;
    assign result.to_port     = out_port_reg;
    assign result.to_app      = out_app_reg;
    assign result.status      = out_status_reg;
    assign result.last        = out_last_reg;

endmodule

`default_nettype wire

/* design/mtms_checker.sv */
// port-level checks for midi_thru_merge_scheduler_unit, bound to the top level
// depends on mtms_pkg and midi_thru_merge_scheduler_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "midi_thru_merge_scheduler_unit_assert.svh"

module mtms_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_ready,
    input wire logic [1:0] item_action,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic       result_to_port,
    input wire logic       result_to_app,
    input wire logic [2:0] result_status,
    input wire logic       result_last
);

    logic item_take;
    logic result_stall;
    logic thru_take;
    logic queue_take;
    logic thru_done;
    logic queue_done;

    assign item_take    = item_valid && item_ready;
    assign result_stall = result_valid && !result_ready;
    assign thru_take    = item_take && (item_action == mtms_pkg::ACT_THRU);
    assign queue_take   = item_take && (item_action == mtms_pkg::ACT_QUEUE);

    assign thru_done = result_valid && result_last &&
                       ((result_status == mtms_pkg::ST_FORWARDED) ||
                        (result_status == mtms_pkg::ST_STRAY) ||
                        (result_status == mtms_pkg::ST_HELD));
    assign queue_done = result_valid && result_last && !result_to_port && !result_to_app &&
                        ((result_status == mtms_pkg::ST_QUEUED) ||
                         (result_status == mtms_pkg::ST_FULL));

    `MTMS_ASSERT_NEXT(a_result_kept, result_stall, result_valid, "result dropped while stalled")

    `MTMS_ASSERT_NOW(a_no_take_on_stall, result_stall, !item_ready, "item taken while stalled")

    `MTMS_ASSERT_NEXT(a_thru_single, thru_take, thru_done, "thru transaction without its result")

    `MTMS_ASSERT_NEXT(a_queue_ack, queue_take, queue_done, "queue transaction without its ack")

endmodule

bind midi_thru_merge_scheduler_unit mtms_checker u_mtms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_action    (item.action),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_to_port (result.to_port),
    .result_to_app  (result.to_app),
    .result_status  (result.status),
    .result_last    (result.last)
);

`default_nettype wire
